### hdl/akf_pkg.sv
// ----------------------------------------------------------------------------
// akf_pkg: shared types and constants of the angle Kalman filter
// Fixed-point formats, register map, sequencer states and the saturation
// helper used by the filter datapath and its divider.
// ----------------------------------------------------------------------------
package akf_pkg;

  // Fixed-point formats.
  localparam int FracBits = 16;            // fraction bits of the state values
  localparam int DtBits   = 16;            // fraction bits of the time step
  localparam int DataW    = 32;            // stored value width
  localparam int CfgW     = 31;            // configuration register width
  localparam int DenW     = DataW + 1;     // divisor width (r_angle + cov_00)
  localparam int CntW     = $clog2(DataW); // divider step counter width

  // Shared multiplier and accumulator widths.
  localparam int OpAW  = DataW + 2;
  localparam int OpBW  = DataW;
  localparam int ProdW = OpAW + OpBW;
  localparam int SumW  = ProdW + 1;

  localparam logic signed [DataW-1:0] OneFx  = DataW'(64'sd1 <<< FracBits);
  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};

  // Configuration port.
  localparam int PAddrW = 4;
  localparam int PDataW = 32;
  localparam logic [1:0] RegRAngle = 2'd0;
  localparam logic [1:0] RegQGyro  = 2'd1;
  localparam logic [1:0] RegQAngle = 2'd2;

  localparam logic [CfgW-1:0] RAngleRst = CfgW'(1966);
  localparam logic [CfgW-1:0] QGyroRst  = CfgW'(197);
  localparam logic [CfgW-1:0] QAngleRst = CfgW'(66);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_GAIN,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } akf_state_e;

  // Destination of one multiply-accumulate operation.
  typedef enum logic [2:0] {
    TGT_ANGLE,
    TGT_BIAS,
    TGT_P00,
    TGT_P01,
    TGT_P10,
    TGT_P11
  } akf_tgt_e;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } akf_div_status_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [DataW-1:0] sat_data(input logic signed [SumW-1:0] v);
    logic ovf;
    ovf = (v[SumW-1:DataW-1] != {(SumW-DataW+1){1'b0}}) &&
          (v[SumW-1:DataW-1] != {(SumW-DataW+1){1'b1}});
    if (!ovf) begin
      return v[DataW-1:0];
    end else if (v[SumW-1]) begin
      return MinVal;
    end else begin
      return MaxVal;
    end
  endfunction

endpackage

### hdl/akf_div.sv
// ----------------------------------------------------------------------------
// akf_div: iterative gain divider
// Computes (num << FracBits) / den, truncated toward zero and clamped to the
// signed 32-bit range, one quotient bit per cycle on magnitudes.
// ----------------------------------------------------------------------------
module akf_div import akf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DataW-1:0]  num_i,
  input  logic signed [DenW-1:0]   den_i,
  output akf_div_status_t          status_o,
  output logic signed [DataW-1:0]  quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DataW-1:0]  rem_q, rem_d;
  logic [DataW-1:0]  quo_q, quo_d;
  logic [DataW-1:0]  den_q, den_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;

  logic [DataW-1:0]       num_mag;
  logic [DenW-1:0]        den_mag;
  logic [DataW+FracBits-1:0] dvd;
  logic [DataW+1:0]       trial;
  logic                   clamp;

  // Magnitudes of the operands; the shifted dividend is split into an upper
  // part (initial remainder) and the 32 bits that are shifted in.
  assign num_mag = num_i[DataW-1] ? (~num_i + DataW'(1)) : num_i;
  assign den_mag = den_i[DenW-1] ? (~den_i + DenW'(1)) : den_i;
  assign dvd     = {num_mag, {FracBits{1'b0}}};
  assign trial   = {1'b0, rem_q, quo_q[DataW-1]} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DataW'(dvd[DataW+FracBits-1:DataW]);
      quo_d  = dvd[DataW-1:0];
      den_d  = den_mag[DataW-1:0];
      neg_d  = num_i[DataW-1] ^ den_i[DenW-1];
      // A quotient of 2^32 or more always clamps.
      ovf_d  = DataW'(dvd[DataW+FracBits-1:DataW]) >= den_mag[DataW-1:0];
    end else if (busy_q) begin
      if (!trial[DataW+1]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == {CntW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    ovf_q <= ovf_d;
  end

  // A positive quotient clamps above 2^31 - 1, a negative one below -2^31.
  assign clamp = ovf_q ||
                 (!neg_q && quo_q[DataW-1]) ||
                 (neg_q && quo_q[DataW-1] && (quo_q[DataW-2:0] != '0));

  always_comb begin
    if (clamp) begin
      quot_o = neg_q ? MinVal : MaxVal;
    end else if (neg_q) begin
      quot_o = -$signed(quo_q);
    end else begin
      quot_o = $signed(quo_q);
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

### hdl/angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_kalman_filter: two-state tilt angle and gyro bias Kalman filter
// Q16.16 fixed point filter with a shared multiply-accumulate unit and an
// iterative gain divider under one sequencer.
// ----------------------------------------------------------------------------
// A predict transaction runs its setup and then its multiply-accumulate schedule; an update
// also runs two gain divisions (one quotient bit per cycle) in between, skipped when the
// innovation variance is zero. The input stalls until the result is in the output register,
// and the next input is taken while it waits there. Reset clears the state to zero angle and
// bias and an identity covariance, and loads the default noise registers.
// ----------------------------------------------------------------------------
module angle_kalman_filter import akf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input transactions.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic signed [DataW-1:0]   gyro_rate_i,
  input  logic [DtBits-1:0]         time_step_i,
  input  logic signed [DataW-1:0]   measured_angle_i,
  // Result transactions.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DataW-1:0]   angle_estimate_o,
  output logic signed [DataW-1:0]   rate_estimate_o,
  output logic signed [DataW-1:0]   bias_estimate_o,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PAddrW-1:0]         paddr,
  input  logic [PDataW-1:0]         pwdata,
  output logic [PDataW-1:0]         prdata,
  output logic                      pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; only the low
  // 31 bits of the data are kept and unused addresses are ignored.
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] r_angle_q, q_gyro_q, q_angle_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_angle_q <= RAngleRst;
      q_gyro_q  <= QGyroRst;
      q_angle_q <= QAngleRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegRAngle: r_angle_q <= pwdata[CfgW-1:0];
        RegQGyro:  q_gyro_q  <= pwdata[CfgW-1:0];
        RegQAngle: q_angle_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegRAngle: prdata = PDataW'(r_angle_q);
      RegQGyro:  prdata = PDataW'(q_gyro_q);
      RegQAngle: prdata = PDataW'(q_angle_q);
      default:   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer. A transaction goes through a setup step (unbiased rate or
  // innovation and its variance), an optional pair of gain divisions, and
  // then a multiply and an accumulate step per scheduled operation.
  // --------------------------------------------------------------------------
  akf_state_e state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [2:0] last_op;
  logic       div_sel_q, div_sel_d;

  logic in_acc;
  logic setup_en, mul_en, acc_en, out_load;
  logic div_start, k0_load, k1_load, k_clear;
  logic s_zero;

  akf_div_status_t         div_status;
  logic signed [DataW-1:0] div_num;
  logic signed [DataW-1:0] div_quot;

  // Latched input transaction.
  logic                    act_q;
  logic signed [DataW-1:0] gyro_q;
  logic [DtBits-1:0]       dt_q;
  logic signed [DataW-1:0] meas_q;

  // Filter state.
  logic signed [DataW-1:0] angle_q, angle_d;
  logic signed [DataW-1:0] bias_q, bias_d;
  logic signed [DataW-1:0] rate_q, rate_d;
  logic signed [DataW-1:0] p00_q, p00_d;
  logic signed [DataW-1:0] p01_q, p01_d;
  logic signed [DataW-1:0] p10_q, p10_d;
  logic signed [DataW-1:0] p11_q, p11_d;

  // Scratch values: aux_a holds the unbiased rate or the innovation, aux_b
  // holds q_angle - P01 - P10 or the innovation variance S.
  logic signed [OpAW-1:0]  aux_a_q, aux_b_q;
  logic signed [DataW-1:0] k0_q, k1_q;

  // Multiply-accumulate unit.
  logic signed [OpAW-1:0]  opa;
  logic signed [OpBW-1:0]  opb;
  logic signed [DataW-1:0] base;
  logic                    sub;
  akf_tgt_e                tgt;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DataW-1:0] base_q;
  logic                    sub_q;
  logic                    dt_scale_q;
  akf_tgt_e                tgt_q;
  logic signed [ProdW-1:0] prod_sh;
  logic signed [SumW-1:0]  acc_sum;
  logic signed [DataW-1:0] acc_res;

  // Output register.
  logic                    out_valid_q;
  logic signed [DataW-1:0] out_angle_q, out_rate_q, out_bias_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_op    = act_q ? 3'd5 : 3'd4;
  assign s_zero     = (aux_b_q == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_GAIN;
      ST_GAIN:  state_d = (!act_q || s_zero) ? ST_MUL : ST_DIV;
      ST_DIV:   if (div_status.done && div_sel_q) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = (op_q == last_op) ? ST_OUT : ST_MUL;
      ST_OUT:   if (!(out_valid_q && out_stall_i)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    setup_en  = (state_q == ST_SETUP);
    mul_en    = (state_q == ST_MUL);
    acc_en    = (state_q == ST_ACC);
    out_load  = (state_q == ST_OUT) && !(out_valid_q && out_stall_i);
    k_clear   = (state_q == ST_GAIN) && act_q && s_zero;
    div_start = ((state_q == ST_GAIN) && act_q && !s_zero) ||
                ((state_q == ST_DIV) && div_status.done && !div_sel_q);
    k0_load   = (state_q == ST_DIV) && div_status.done && !div_sel_q;
    k1_load   = (state_q == ST_DIV) && div_status.done && div_sel_q;
    // The first division yields K0 from P00, the second K1 from P10.
    div_num   = (state_q == ST_GAIN) ? p00_q : p10_q;
    div_sel_d = div_sel_q;
    if (state_q == ST_GAIN) begin
      div_sel_d = 1'b0;
    end else if (k0_load) begin
      div_sel_d = 1'b1;
    end
    op_d = op_q;
    if (in_acc) begin
      op_d = '0;
    end else if (acc_en) begin
      op_d = op_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= '0;
      div_sel_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      div_sel_q <= div_sel_d;
    end
  end

  akf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (aux_b_q[DenW-1:0]),
    .status_o (div_status),
    .quot_o   (div_quot)
  );

  // --------------------------------------------------------------------------
  // Operation schedule. Predict scales by the time step; the angle goes
  // first and P00 before the P01/P10 terms it reads. Update writes P10 and
  // P11 before P00 and P01 so every covariance term sees the old matrix.
  // --------------------------------------------------------------------------
  always_comb begin
    opa  = '0;
    opb  = '0;
    base = angle_q;
    sub  = 1'b0;
    tgt  = TGT_ANGLE;
    if (!act_q) begin
      opb = OpBW'($signed({1'b0, dt_q}));
      unique case (op_q)
        3'd0: begin
          opa = aux_a_q; base = angle_q; tgt = TGT_ANGLE;
        end
        3'd1: begin
          opa = aux_b_q; base = p00_q; tgt = TGT_P00;
        end
        3'd2: begin
          opa = -OpAW'(p11_q); base = p01_q; tgt = TGT_P01;
        end
        3'd3: begin
          opa = -OpAW'(p11_q); base = p10_q; tgt = TGT_P10;
        end
        3'd4: begin
          opa = OpAW'($signed({1'b0, q_gyro_q})); base = p11_q; tgt = TGT_P11;
        end
        default: ;
      endcase
    end else begin
      unique case (op_q)
        3'd0: begin
          opa = OpAW'(k1_q); opb = p00_q; base = p10_q; sub = 1'b1; tgt = TGT_P10;
        end
        3'd1: begin
          opa = OpAW'(k1_q); opb = p01_q; base = p11_q; sub = 1'b1; tgt = TGT_P11;
        end
        3'd2: begin
          opa = OpAW'(k0_q); opb = p00_q; base = p00_q; sub = 1'b1; tgt = TGT_P00;
        end
        3'd3: begin
          opa = OpAW'(k0_q); opb = p01_q; base = p01_q; sub = 1'b1; tgt = TGT_P01;
        end
        3'd4: begin
          opa = OpAW'(k0_q); opb = aux_a_q[DataW-1:0]; base = angle_q; tgt = TGT_ANGLE;
        end
        3'd5: begin
          opa = OpAW'(k1_q); opb = aux_a_q[DataW-1:0]; base = bias_q; tgt = TGT_BIAS;
        end
        default: ;
      endcase
    end
  end

  // Product register: the multiply cycle latches the product together with
  // the value it corrects and where the result goes.
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q     <= opa * opb;
      base_q     <= base;
      sub_q      <= sub;
      dt_scale_q <= !act_q;
      tgt_q      <= tgt;
    end
  end

  // Accumulate cycle: arithmetic shifts round toward minus infinity, then
  // the corrected value is clamped to 32 bits.
  assign prod_sh = dt_scale_q ? (prod_q >>> DtBits) : (prod_q >>> FracBits);
  assign acc_sum = sub_q ? (SumW'(base_q) - SumW'(prod_sh))
                         : (SumW'(base_q) + SumW'(prod_sh));
  assign acc_res = sat_data(acc_sum);

  // --------------------------------------------------------------------------
  // Input latch, scratch values and gains.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_i;
      gyro_q <= gyro_rate_i;
      dt_q   <= time_step_i;
      meas_q <= measured_angle_i;
    end
    if (setup_en) begin
      if (!act_q) begin
        aux_a_q <= OpAW'(gyro_q) - OpAW'(bias_q);
        aux_b_q <= OpAW'($signed({1'b0, q_angle_q})) - OpAW'(p01_q) - OpAW'(p10_q);
      end else begin
        aux_a_q <= OpAW'(sat_data(SumW'(meas_q) - SumW'(angle_q)));
        aux_b_q <= OpAW'($signed({1'b0, r_angle_q})) + OpAW'(p00_q);
      end
    end
    if (k_clear) begin
      k0_q <= '0;
      k1_q <= '0;
    end else begin
      if (k0_load) k0_q <= div_quot;
      if (k1_load) k1_q <= div_quot;
    end
  end

  // --------------------------------------------------------------------------
  // Filter state write-back.
  // --------------------------------------------------------------------------
  always_comb begin
    angle_d = angle_q;
    bias_d  = bias_q;
    rate_d  = rate_q;
    p00_d   = p00_q;
    p01_d   = p01_q;
    p10_d   = p10_q;
    p11_d   = p11_q;
    if (setup_en && !act_q) begin
      rate_d = sat_data(SumW'(gyro_q) - SumW'(bias_q));
    end
    if (acc_en) begin
      unique case (tgt_q)
        TGT_ANGLE: angle_d = acc_res;
        TGT_BIAS:  bias_d  = acc_res;
        TGT_P00:   p00_d   = acc_res;
        TGT_P01:   p01_d   = acc_res;
        TGT_P10:   p10_d   = acc_res;
        TGT_P11:   p11_d   = acc_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      rate_q  <= '0;
      p00_q   <= OneFx;
      p01_q   <= '0;
      p10_q   <= '0;
      p11_q   <= OneFx;
    end else begin
      angle_q <= angle_d;
      bias_q  <= bias_d;
      rate_q  <= rate_d;
      p00_q   <= p00_d;
      p01_q   <= p01_d;
      p10_q   <= p10_d;
      p11_q   <= p11_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It holds a finished result until the consumer takes it,
  // so the next input transaction can already be worked on.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_angle_q <= angle_q;
      out_rate_q  <= rate_q;
      out_bias_q  <= bias_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign angle_estimate_o = out_angle_q;
  assign rate_estimate_o  = out_rate_q;
  assign bias_estimate_o  = out_bias_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The divider is never restarted while it is still iterating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  // Divisions only run for an update with a nonzero innovation variance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (act_q && !s_zero))
    else $error("gain division without a valid divisor");

  // A division result only arrives while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == ST_DIV))
    else $error("divider result outside the division phase");

  // The operation index never runs past the schedule of the action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_ACC) |-> (op_q <= last_op))
    else $error("operation index out of range");

  // A new result only appears after the final write-back phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result presented outside the output phase");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the angle Kalman filter
// Drives predict and update transactions through the valid/stall input,
// keeps a bit-exact fixed-point model of the filter state and covariance,
// and compares every result transaction field by field. The noise registers
// are written and read back over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import akf_pkg::*;

  // Action codes of an input transaction.
  localparam logic ActPredict = 1'b0;
  localparam logic ActUpdate  = 1'b1;

  // Register index that maps to no register.
  localparam logic [1:0] RegUnused = 2'd3;

  localparam int ClkHalf          = 6;
  localparam int ResetCycles      = 10;
  // This covers the slowest transaction, an update with two gain divisions.
  localparam int SettleCycles     = 100;
  localparam int LongHoldCycles   = 400;
  localparam int CycleLimit       = 1_000_000;
  localparam int RandomPhases     = 6;
  localparam int ItemsPerPhase    = 140;
  localparam int PressureItems    = 20;
  localparam int MaxPrintedErrors = 40;

  localparam logic signed [63:0] Max32  = 64'sd2147483647;
  localparam logic signed [63:0] Min32  = -64'sd2147483648;
  localparam logic [CfgW-1:0]    CfgMax = '1;

  typedef struct packed {
    logic [DataW-1:0] angle;
    logic [DataW-1:0] rate;
    logic [DataW-1:0] bias;
  } filter_result_t;

  // DUT signals.
  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    action_i;
  logic signed [DataW-1:0] gyro_rate_i;
  logic [DtBits-1:0]       time_step_i;
  logic signed [DataW-1:0] measured_angle_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [DataW-1:0] angle_estimate_o;
  logic signed [DataW-1:0] rate_estimate_o;
  logic signed [DataW-1:0] bias_estimate_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PAddrW-1:0]       paddr;
  logic [PDataW-1:0]       pwdata;
  logic [PDataW-1:0]       prdata;
  logic                    pready;

  // Model of the filter: state, covariance and noise registers, all held
  // in 64 bits so that sums and products are exact before saturation.
  logic signed [63:0] est_angle, est_bias, est_rate;
  logic signed [63:0] cov00, cov01, cov10, cov11;
  logic signed [63:0] cfg_r_angle, cfg_q_gyro, cfg_q_angle;

  // Estimates that the filter still owes, oldest first.
  filter_result_t pending_estimates[$];
  filter_result_t owed;

  // Sender state: the input valid is high while a transaction is offered.
  bit offering;
  bit sender_gaps;
  int burst_left;

  // Each increment asks the receiver for one long hold-off.
  int hold_requests;

  int error_count;
  int cycle_count;
  int results_checked;
  int predict_count;
  int update_count;
  int zero_variance_count;
  int negative_variance_count;
  int cfg_write_count;

  angle_kalman_filter uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .gyro_rate_i      (gyro_rate_i),
    .time_step_i      (time_step_i),
    .measured_angle_i (measured_angle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .angle_estimate_o (angle_estimate_o),
    .rate_estimate_o  (rate_estimate_o),
    .bias_estimate_o  (bias_estimate_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Filter model
  // --------------------------------------------------------------------------

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > Max32) begin
      return Max32;
    end else if (v < Min32) begin
      return Min32;
    end
    return v;
  endfunction

  // Kalman gain in fixed point. The division truncates toward zero, and a
  // zero innovation variance gives a zero gain so the update changes nothing.
  function automatic logic signed [63:0] kalman_gain(input logic signed [63:0] num,
                                                     input logic signed [63:0] s);
    if (s == 0) begin
      return 0;
    end
    return clamp32((num <<< FracBits) / s);
  endfunction

  task automatic filter_reset();
    est_angle   = 0;
    est_bias    = 0;
    est_rate    = 0;
    cov00       = 64'sd1 <<< FracBits;
    cov01       = 0;
    cov10       = 0;
    cov11       = 64'sd1 <<< FracBits;
    cfg_r_angle = {33'd0, RAngleRst};
    cfg_q_gyro  = {33'd0, QGyroRst};
    cfg_q_angle = {33'd0, QAngleRst};
  endtask

  // Advances the model by one accepted transaction and queues the estimate
  // that the filter must return for it. The arithmetic right shift of a
  // signed product rounds toward minus infinity, as the datapath does.
  task automatic filter_step(input logic act, input logic signed [DataW-1:0] gyro,
                             input logic [DtBits-1:0] dt_raw,
                             input logic signed [DataW-1:0] meas);
    logic signed [63:0] dt, unbiased, innov, s, k0, k1;
    logic signed [63:0] p00, p01, p10, p11;
    p00 = cov00;
    p01 = cov01;
    p10 = cov10;
    p11 = cov11;
    if (act == ActPredict) begin
      predict_count++;
      dt       = {48'd0, dt_raw};
      unbiased = gyro - est_bias;
      est_rate  = clamp32(unbiased);
      est_angle = clamp32(est_angle + ((unbiased * dt) >>> DtBits));
      cov00 = clamp32(p00 + (((cfg_q_angle - p01 - p10) * dt) >>> DtBits));
      cov01 = clamp32(p01 + (((-p11) * dt) >>> DtBits));
      cov10 = clamp32(p10 + (((-p11) * dt) >>> DtBits));
      cov11 = clamp32(p11 + ((cfg_q_gyro * dt) >>> DtBits));
    end else begin
      update_count++;
      innov = clamp32(meas - est_angle);
      s     = cfg_r_angle + p00;
      if (s == 0) begin
        zero_variance_count++;
      end else if (s < 0) begin
        negative_variance_count++;
      end
      k0 = kalman_gain(p00, s);
      k1 = kalman_gain(p10, s);
      // The covariance correction reads only the values from before it.
      cov00 = clamp32(p00 - ((k0 * p00) >>> FracBits));
      cov01 = clamp32(p01 - ((k0 * p01) >>> FracBits));
      cov10 = clamp32(p10 - ((k1 * p00) >>> FracBits));
      cov11 = clamp32(p11 - ((k1 * p01) >>> FracBits));
      est_angle = clamp32(est_angle + ((k0 * innov) >>> FracBits));
      est_bias  = clamp32(est_bias + ((k1 * innov) >>> FracBits));
    end
    pending_estimates.push_back({est_angle[DataW-1:0], est_rate[DataW-1:0],
                                 est_bias[DataW-1:0]});
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxPrintedErrors) begin
      $display("MISMATCH %s: got %h, wanted %h (cycle %0d)", what, got, want, cycle_count);
    end
  endtask

  // A result transaction completes at an edge where out_valid_o is high and
  // out_stall_i is low. Both are read before the edge updates anything.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("result with no transaction outstanding", angle_estimate_o, '0);
      end else begin
        owed = pending_estimates.pop_front();
        results_checked++;
        if (angle_estimate_o !== owed.angle) begin
          report_mismatch("angle_estimate", angle_estimate_o, owed.angle);
        end
        if (rate_estimate_o !== owed.rate) begin
          report_mismatch("rate_estimate", rate_estimate_o, owed.rate);
        end
        if (bias_estimate_o !== owed.bias) begin
          report_mismatch("bias_estimate", bias_estimate_o, owed.bias);
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls the result channel on a pattern of its own. The mode
  // changes at random intervals between no stalls, sparse and dense random
  // stalls and a periodic one. A long hold-off, counted here, is served
  // whenever the test sequence asks for one.
  // --------------------------------------------------------------------------
  initial begin : receiver_stall
    int mode;
    int mode_left;
    int hold_left;
    int holds_served;
    int tick;
    out_stall_i  = 1'b0;
    mode         = 0;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    tick         = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LongHoldCycles;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and configuration port
  // --------------------------------------------------------------------------

  // Offers one transaction and returns once it is accepted. The payload
  // holds while the filter stalls. Transactions go out in bursts; after a
  // burst, unless gaps are off, the valid drops for a random gap, short most
  // of the time and sometimes long enough to land on any step of an update.
  task automatic send_item(input logic act, input logic [DataW-1:0] gyro,
                           input logic [DtBits-1:0] dt, input logic [DataW-1:0] meas);
    int gap;
    in_valid_i       <= 1'b1;
    action_i         <= act;
    gyro_rate_i      <= gyro;
    time_step_i      <= dt;
    measured_angle_i <= meas;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    filter_step(act, gyro, dt, meas);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = 0;
      if (sender_gaps) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stops offering and waits until every owed estimate has arrived and the
  // filter has had time to go quiet.
  task automatic settle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes one register with a setup and an access phase, updates the
  // model, and reads the register back where the index maps to one.
  task automatic apb_write(input logic [1:0] idx, input logic [PDataW-1:0] data);
    logic [CfgW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_write_count++;
    // Bits above the register width are dropped.
    case (idx)
      RegRAngle: cfg_r_angle = {33'd0, data[CfgW-1:0]};
      RegQGyro:  cfg_q_gyro  = {33'd0, data[CfgW-1:0]};
      RegQAngle: cfg_q_angle = {33'd0, data[CfgW-1:0]};
      default:   ;
    endcase
    @(posedge clk_i);
    if (idx != RegUnused) begin
      case (idx)
        RegRAngle: want = cfg_r_angle[CfgW-1:0];
        RegQGyro:  want = cfg_q_gyro[CfgW-1:0];
        default:   want = cfg_q_angle[CfgW-1:0];
      endcase
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata[CfgW-1:0] !== want) begin
        report_mismatch("register read-back", prdata, {1'b0, want});
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic load_default_noise();
    apb_write(RegRAngle, {1'b0, RAngleRst});
    apb_write(RegQGyro, {1'b0, QGyroRst});
    apb_write(RegQAngle, {1'b0, QAngleRst});
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The first writes restore the reset values: each register gets
  // its default with the top bit of the write data set, which must be
  // dropped, and a write to the address past the last register must leave
  // all three untouched.
  task automatic test_register_access();
    apb_write(RegUnused, 32'hFFFF_FFFF);
    apb_write(RegRAngle, {1'b1, RAngleRst});
    apb_write(RegQGyro, {1'b1, QGyroRst});
    apb_write(RegQAngle, {1'b1, QAngleRst});
    apb_write(RegUnused, 32'h0000_0000);
  endtask

  // From the reset covariance, two full-second predicts with the largest
  // bias noise saturate P11 and drive P01 and P10 to the negative limit.
  // An update with no measurement noise then flips P11 to the negative
  // limit, after which two more predicts make P00 hugely negative, so the
  // final update divides by a negative innovation variance.
  task automatic test_negative_variance();
    apb_write(RegQAngle, '0);
    apb_write(RegQGyro, {1'b0, CfgMax});
    apb_write(RegRAngle, '0);
    send_item(ActPredict, 32'h0001_0000, 16'hFFFF, 32'h0000_0000);
    send_item(ActPredict, 32'hFFFF_0000, 16'hFFFF, 32'h0000_0000);
    send_item(ActUpdate, 32'h0000_0000, 16'h0000, 32'h0002_0000);
    send_item(ActPredict, 32'h0000_8000, 16'hFFFF, 32'h0000_0000);
    send_item(ActPredict, 32'hFFFF_8000, 16'hFFFF, 32'h0000_0000);
    send_item(ActUpdate, 32'h0000_0000, 16'h0000, 32'hFFFE_0000);
    settle();
  endtask

  // With no measurement noise the first update drives P00 to exactly zero,
  // so the innovation variance of the following updates is zero and they
  // must leave the state alone. A predict with a zero time step in between
  // keeps P00 at zero.
  task automatic test_zero_variance();
    apb_write(RegRAngle, '0);
    send_item(ActUpdate, 32'h0000_0000, 16'h0000, 32'h0001_0000);
    send_item(ActUpdate, 32'h0000_0000, 16'h0000, 32'hFFF0_0000);
    send_item(ActPredict, 32'h0000_1234, 16'h0000, 32'h0000_0000);
    send_item(ActUpdate, 32'h7FFF_FFFF, 16'hFFFF, 32'h0123_4567);
    settle();
    load_default_noise();
  endtask

  // Field extremes for both actions, with the unused fields of each
  // transaction set to extremes too, since the filter must ignore them.
  task automatic test_field_extremes();
    send_item(ActPredict, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
    send_item(ActPredict, 32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(ActPredict, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
    send_item(ActPredict, 32'hFFFF_FFFF, 16'h0001, 32'h0000_0000);
    send_item(ActUpdate, 32'hFFFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(ActUpdate, 32'h0000_0000, 16'h0000, 32'h8000_0000);
    send_item(ActUpdate, 32'h8000_0000, 16'hFFFF, 32'h0000_0000);
    send_item(ActUpdate, 32'h0000_0007, 16'h0001, 32'hFFFF_FFFF);
    settle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back to back: the output register fills, one more transaction
  // is taken, and then the filter must stall its input and lose nothing.
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    hold_requests++;
    repeat (PressureItems) begin
      send_item(1'($urandom_range(0, 1)), $urandom(), DtBits'($urandom()), $urandom());
    end
    settle();
    sender_gaps = 1'b1;
  endtask

  // One random transaction. Most are plausible IMU traffic: small gyro
  // rates over millisecond steps and measurements close to the current
  // angle, so the filter converges and then tracks. The rest carry fully
  // random fields, which reach the saturation corners.
  task automatic random_transaction();
    int pick;
    logic act;
    logic [DataW-1:0] gyro, meas;
    logic [DtBits-1:0] dt;
    pick = $urandom_range(0, 99);
    gyro = $urandom();
    meas = $urandom();
    dt   = DtBits'($urandom());
    if (pick < 45) begin
      act  = ActPredict;
      gyro = DataW'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      if ($urandom_range(0, 9) != 0) begin
        dt = DtBits'($urandom_range(65, 6554));
      end
    end else if (pick < 80) begin
      act  = ActUpdate;
      meas = est_angle[DataW-1:0] + DataW'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    end else begin
      act = 1'($urandom_range(0, 1));
    end
    send_item(act, gyro, dt, meas);
  endtask

  // Random traffic under several noise settings: all registers at their
  // largest value, all at zero, the defaults, then random mixes. One phase
  // runs the sender without gaps.
  task automatic test_random_phases();
    logic [PDataW-1:0] value;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      settle();
      for (int idx = 0; idx < 3; idx++) begin
        case (phase)
          0:       value = {1'b1, CfgMax};
          1:       value = '0;
          2:       value = (idx == 0) ? {1'b0, RAngleRst} :
                           (idx == 1) ? {1'b0, QGyroRst} : {1'b0, QAngleRst};
          default: begin
            case ($urandom_range(0, 3))
              0:       value = {1'b0, CfgMax};
              1:       value = $urandom_range(0, 4095);
              2:       value = $urandom_range(0, 200000);
              default: value = $urandom();
            endcase
          end
        endcase
        apb_write(idx[1:0], value);
      end
      apb_write(RegUnused, $urandom());
      sender_gaps = (phase != 2);
      repeat (ItemsPerPhase) random_transaction();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    action_i         = ActPredict;
    gyro_rate_i      = '0;
    time_step_i      = '0;
    measured_angle_i = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    offering         = 1'b0;
    sender_gaps      = 1'b1;
    burst_left       = 0;
    hold_requests    = 0;
    error_count      = 0;
    results_checked  = 0;
    predict_count    = 0;
    update_count     = 0;
    zero_variance_count     = 0;
    negative_variance_count = 0;
    cfg_write_count  = 0;
    filter_reset();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_negative_variance();
    test_zero_variance();
    test_field_extremes();
    test_output_backpressure();
    test_random_phases();

    // Everything has been sent; wait for the last estimates, then give any
    // stray result time to show up.
    settle();

    $display("Covered %0d predict and %0d update transactions, %0d register writes.",
             predict_count, update_count, cfg_write_count);
    $display("Innovation variance zero %0d times, negative %0d times; %0d results checked.",
             zero_variance_count, negative_variance_count, results_checked);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/akf_pkg.sv
hdl/akf_div.sv
hdl/angle_kalman_filter.sv
tb/tb_top.sv
